// ===== hw/rtl/pswm_pkg.sv =====
`default_nettype none
package pswm_pkg;

  localparam int TYPES_DEF  = 16;
  localparam int WINDOW_DEF = 8;

  localparam int OP_W   = 2;
  localparam int TYPE_W = 4;
  localparam int ID_W   = 32;
  localparam int INST_W = 32;
  localparam int IPC_W  = 16;

  localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TYPE_W-1:0] task_kind;
    logic [ID_W-1:0]   task_id;
    logic [INST_W-1:0] inst_count;
    logic [IPC_W-1:0]  ipc;
  } in_item_t;

  typedef struct packed {
    logic [IPC_W-1:0] mean_ipc;
    logic             has_valid;
    logic [ID_W-1:0]  last_id;
    logic             all_full;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_LOAD,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pswm_ctrl.sv =====
`default_nettype none
module pswm_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire                 out_stall,
  input  pswm_pkg::sts_t      sts,
  output pswm_pkg::cmd_t      cmd
);

  pswm_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pswm_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pswm_pkg::S_IDLE: begin
        if (in_valid) state_nxt = pswm_pkg::S_UPD;
      end
      pswm_pkg::S_UPD:  state_nxt = pswm_pkg::S_LOAD;
      pswm_pkg::S_LOAD: state_nxt = pswm_pkg::S_DIV;
      pswm_pkg::S_DIV: begin
        if (sts.div_last) state_nxt = pswm_pkg::S_FIN;
      end
      pswm_pkg::S_FIN: begin
        if (!out_valid_r || !out_stall) state_nxt = pswm_pkg::S_IDLE;
      end
      default: state_nxt = pswm_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      pswm_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      pswm_pkg::S_UPD:  cmd.update    = 1'b1;
      pswm_pkg::S_LOAD: cmd.div_start = 1'b1;
      pswm_pkg::S_DIV:  cmd.div_step  = 1'b1;
      pswm_pkg::S_FIN:  cmd.out_load  = !out_valid_r || !out_stall;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

  a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pswm_pkg::S_DIV && sts.div_last) |=> state_r == pswm_pkg::S_FIN)
    else $error("divider finished but result not moved to output stage");

  a_fin_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pswm_pkg::S_FIN && !cmd.out_load) |-> (out_valid_r && out_stall))
    else $error("finished result held back with output register free");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (out_valid && state_r == pswm_pkg::S_IDLE))
    else $error("loaded result not presented");

endmodule
`default_nettype wire

// ===== hw/rtl/pswm_dp.sv =====
`default_nettype none
module pswm_dp #(
  parameter int TYPES  = pswm_pkg::TYPES_DEF,
  parameter int WINDOW = pswm_pkg::WINDOW_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  pswm_pkg::in_item_t   in_data,
  input  pswm_pkg::cmd_t       cmd,
  output pswm_pkg::sts_t       sts,
  output pswm_pkg::out_item_t  out_data
);

  // only types that the 4-bit field can name get storage
  localparam int NT    = (TYPES < (1 << pswm_pkg::TYPE_W)) ? TYPES : (1 << pswm_pkg::TYPE_W);
  localparam int TIW   = (NT > 1) ? $clog2(NT) : 1;
  localparam int SLW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int SW    = pswm_pkg::IPC_W + $clog2(WINDOW);
  localparam int DEPTH = NT * WINDOW;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW    = $clog2(NT + 1);
  localparam int DCW   = (SW > 1) ? $clog2(SW) : 1;
  localparam int IPC_W = pswm_pkg::IPC_W;

  logic [IPC_W:0]            mem [DEPTH];
  logic [IPC_W:0]            rd_r;
  logic [AW-1:0]             addr_r;
  pswm_pkg::in_item_t        item_r;

  logic [SLW-1:0]            wslot_r [NT];
  logic                      wrap_r  [NT];
  logic [CW-1:0]             nval_r  [NT];
  logic [SW-1:0]             sum_r   [NT];
  logic [pswm_pkg::ID_W-1:0] lid_r   [NT];
  logic [KW-1:0]             known_r;

  logic [SW-1:0]             dvd_r;
  logic [CW-1:0]             dvs_r;
  logic [CW-1:0]             rem_r;
  logic [IPC_W-1:0]          quo_r;
  logic [DCW-1:0]            dcnt_r;
  logic                      hv_r;
  logic [pswm_pkg::ID_W-1:0] lidq_r;
  logic                      afull_r;

  logic [TIW-1:0] t_in, t_i;
  logic [AW-1:0]  addr_in;
  logic           in_range, is_rec, is_clr, old_v, new_v, afull;
  logic [IPC_W-1:0] old_ipc, new_ipc;
  logic [KW-1:0]  t_plus1;
  logic [CW:0]    trial;
  logic           ge;

  assign t_in    = in_data.task_kind[TIW-1:0];
  assign addr_in = AW'(AW'(t_in) * AW'(WINDOW)) + AW'(wslot_r[t_in]);

  assign t_i      = item_r.task_kind[TIW-1:0];
  assign in_range = 32'(item_r.task_kind) < TYPES;
  assign is_rec   = (item_r.op == pswm_pkg::OP_RECORD) && in_range;
  assign is_clr   = item_r.op == pswm_pkg::OP_CLEAR;
  // the slot being replaced only holds a live sample once the window has wrapped
  assign old_v    = wrap_r[t_i] & rd_r[IPC_W];
  assign old_ipc  = old_v ? rd_r[IPC_W-1:0] : '0;
  assign new_v    = item_r.inst_count != '0;
  assign new_ipc  = new_v ? item_r.ipc : '0;
  assign t_plus1  = KW'(t_i) + KW'(1);

  // sample memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_r   <= mem[addr_in];
      addr_r <= addr_in;
      item_r <= in_data;
    end
    if (cmd.update && is_rec) mem[addr_r] <= {new_v, new_ipc};
  end

  // per-type window summary
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r <= '0;
      for (int k = 0; k < NT; k++) begin
        wslot_r[k] <= '0;
        wrap_r[k]  <= 1'b0;
        nval_r[k]  <= '0;
        sum_r[k]   <= '0;
        lid_r[k]   <= '0;
      end
    end else if (cmd.update) begin
      if (is_rec) begin
        if (wslot_r[t_i] == SLW'(WINDOW - 1)) begin
          wslot_r[t_i] <= '0;
          wrap_r[t_i]  <= 1'b1;
        end else begin
          wslot_r[t_i] <= wslot_r[t_i] + SLW'(1);
        end
        nval_r[t_i] <= nval_r[t_i] - CW'(old_v) + CW'(new_v);
        sum_r[t_i]  <= sum_r[t_i] - SW'(old_ipc) + SW'(new_ipc);
        lid_r[t_i]  <= item_r.task_id;
        if (t_plus1 > known_r) known_r <= t_plus1;
      end else if (is_clr) begin
        known_r <= '0;
        for (int k = 0; k < NT; k++) begin
          wslot_r[k] <= '0;
          wrap_r[k]  <= 1'b0;
          nval_r[k]  <= '0;
          sum_r[k]   <= '0;
        end
      end
    end
  end

  // type 0 is never checked
  always_comb begin
    afull = known_r != '0;
    for (int k = 1; k < NT; k++) begin
      if (KW'(k) < known_r && nval_r[k] != CW'(WINDOW)) afull = 1'b0;
    end
  end

  // restoring divider, one quotient bit a cycle
  assign trial = {rem_r, dvd_r[SW-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_r   <= in_range ? sum_r[t_i] : '0;
      dvs_r   <= in_range ? nval_r[t_i] : '0;
      hv_r    <= in_range && KW'(t_i) < known_r && nval_r[t_i] != '0;
      lidq_r  <= in_range ? lid_r[t_i] : '0;
      afull_r <= afull;
      rem_r   <= '0;
      quo_r   <= '0;
      dcnt_r  <= DCW'(SW - 1);
    end else if (cmd.div_step) begin
      rem_r  <= ge ? CW'(trial - {1'b0, dvs_r}) : CW'(trial);
      dvd_r  <= {dvd_r[SW-2:0], 1'b0};
      quo_r  <= {quo_r[IPC_W-2:0], ge};
      dcnt_r <= dcnt_r - DCW'(1);
    end
  end

  assign sts.div_last = dcnt_r == '0;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.mean_ipc  <= hv_r ? quo_r : '0;
      out_data.has_valid <= hv_r;
      out_data.last_id   <= lidq_r;
      out_data.all_full  <= afull_r;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && dvs_r != '0) |-> rem_r < dvs_r)
    else $error("divider remainder not below divisor");

  a_clear_known: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && is_clr) |=> known_r == '0)
    else $error("clear left known types");

  a_rec_known: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && is_rec) |=> known_r > KW'($past(t_i)))
    else $error("recorded type not counted as known");

endmodule
`default_nettype wire

// ===== hw/rtl/per_type_sample_window_mean_top.sv =====
// per-type sample window mean
// input channel in_valid / in_stall / in_data carries one op (record, query, clear) per item;
// result channel out_valid / out_stall / out_data returns one result item per input item,
// in order. an item is taken on a rising edge with valid high and stall low.
// per type a running sum and valid count of the window are kept next to the sample
// memory, so a record replaces the oldest sample in place and a clear needs no pass over it.
// the mean comes from a restoring divider giving one quotient bit a cycle over
// SW = 16 + log2(WINDOW) bits.
// in_stall is high from acceptance until the result moves into the output register, so the
// divider sets the pace and a new item is taken only once the last one has left it.
// the output register lets the next item enter while an earlier result still waits;
// a stalled receiver holds out_data steady and, once the next result is ready,
// holds the block with in_stall high.
// reset (rst_n low, synchronous) empties all windows, zeroes the last ids and the known
// type count and drops out_valid; the sample memory needs no clearing pass.
`default_nettype none
module per_type_sample_window_mean_top #(
  parameter int TYPES  = pswm_pkg::TYPES_DEF,
  parameter int WINDOW = pswm_pkg::WINDOW_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  pswm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output pswm_pkg::out_item_t  out_data
);

  pswm_pkg::cmd_t cmd;
  pswm_pkg::sts_t sts;

  pswm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pswm_dp #(
    .TYPES  (TYPES),
    .WINDOW (WINDOW)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
